@@ rtl/core/window_neighbor_pair_counter_defines.svh @@
// Assertion macros for the window neighbor pair counter.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef WINDOW_NEIGHBOR_PAIR_COUNTER_DEFINES_SVH
`define WINDOW_NEIGHBOR_PAIR_COUNTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WNPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WNPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wnpc_pkg.sv @@
// Shared widths, constants and types of the window neighbor pair counter.
// No dependencies; the interfaces, the result stage and the top import it.
package wnpc_pkg;

  localparam int CHROM_W = 16;
  localparam int POS_W   = 31;
  localparam int IDX_W   = 31;
  localparam int CNT_W   = 6;

  localparam logic [CNT_W-1:0] TALLY_MAX    = 6'd63;
  localparam logic [POS_W-1:0] RADIUS_RESET = 31'd1000000;

  typedef struct packed {
    logic [CHROM_W-1:0] first_chrom;
    logic [POS_W-1:0]   first_pos;
    logic [CHROM_W-1:0] second_chrom;
    logic [POS_W-1:0]   second_pos;
    logic [IDX_W-1:0]   index;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } res_t;

  typedef struct packed {
    logic push;
    logic finish;
    res_t res;
  } rq_ctl_t;

endpackage

@@ rtl/core/wnpc_pair_if.sv @@
// Input channel of the window neighbor pair counter: one contact pair per word.
// Depends on wnpc_pkg.
interface wnpc_pair_if;
  import wnpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHROM_W-1:0] first_chrom;
  logic [POS_W-1:0]   first_pos;
  logic [CHROM_W-1:0] second_chrom;
  logic [POS_W-1:0]   second_pos;
  logic [IDX_W-1:0]   item_index;
  logic               last_item;

  modport source (
    output valid, first_chrom, first_pos, second_chrom, second_pos, item_index, last_item,
    input  ready
  );

  modport sink (
    input  valid, first_chrom, first_pos, second_chrom, second_pos, item_index, last_item,
    output ready
  );
endinterface

@@ rtl/core/wnpc_count_if.sv @@
// Output channel of the window neighbor pair counter: one final count per word.
// Depends on wnpc_pkg.
interface wnpc_count_if;
  import wnpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic [CNT_W-1:0] neighbor_count;
  logic             window_overflow;
  logic             last_result;

  modport source (
    output valid, result_index, neighbor_count, window_overflow, last_result,
    input  ready
  );

  modport sink (
    input  valid, result_index, neighbor_count, window_overflow, last_result,
    output ready
  );
endinterface

@@ rtl/core/wnpc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wnpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/wnpc_result_q.sv @@
// Result stage: a pending word plus the output register; marks the last word of an item.
// Depends on wnpc_pkg and wnpc_count_if.
module wnpc_result_q (
  input  logic             clk,
  input  logic             rst,
  input  wnpc_pkg::rq_ctl_t ctl,
  output logic             rdy,
  wnpc_count_if.source     counts
);
  import wnpc_pkg::*;

  logic pend_v;
  res_t pend;
  logic out_free;
  logic move;

  assign out_free = !counts.valid || counts.ready;
  assign rdy      = !pend_v || out_free;
  assign move     = (ctl.push || ctl.finish) && rdy && pend_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v       <= 1'b0;
      counts.valid <= 1'b0;
    end else begin
      if (move) begin
        counts.valid <= 1'b1;
      end else if (counts.ready) begin
        counts.valid <= 1'b0;
      end
      if (ctl.push && rdy) begin
        pend_v <= 1'b1;
      end else if (ctl.finish && rdy) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && rdy) begin
      pend <= ctl.res;
    end
    if (move) begin
      counts.result_index    <= pend.idx;
      counts.neighbor_count  <= pend.count;
      counts.window_overflow <= pend.ovf;
      counts.last_result     <= ctl.finish;
    end
  end

endmodule

@@ rtl/core/window_neighbor_pair_counter.sv @@
// Window neighbor pair counter: input channel pairs, output channel counts, one config register.
// A window of open pairs lives in an entry RAM and a tally RAM; the top sequences every word.
// Depends on wnpc_pkg, wnpc_pair_if, wnpc_count_if, wnpc_ram, wnpc_result_q and the defines header.
//
// Usage:
//  pairs carries one contact pair per word, sorted by first end; last_item closes a stream.
//  counts carries one word per pair leaving the window: its index, its final neighbor count,
//  an overflow flag when the full window forced it out, and last_result on the final word
//  caused by one input word. cfg_we writes cfg_data to radius; the user must assert it only
//  while the block is idle, which the block itself does not enforce. One pair is worked at a
//  time. Its steps are: accept, age out pairs from the window (compare then RAM read per
//  pair), an age check that keeps the rest, a scan of the open pairs through the single read
//  port of the window RAMs, insert, a final flush of every open pair on last_item, and close.
//  A word waits in the pending register until the next word or the close pushes it out.
//  Reset empties the window and sets radius to 1000000; RAM contents need no clearing.
//  When counts stalls, the block holds one pending word and the output word, then waits
//  with ready low until the receiver takes a word.
`include "window_neighbor_pair_counter_defines.svh"

module window_neighbor_pair_counter #(
  parameter int WINDOW = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [wnpc_pkg::POS_W-1:0] cfg_data,
  wnpc_pair_if.sink                  pairs,
  wnpc_count_if.source               counts
);
  import wnpc_pkg::*;

  localparam int SW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [CW-1:0] WIN_CNT  = CW'(WINDOW);
  localparam logic [SW:0]   WIN_WRAP = (SW + 1)'(WINDOW);
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_INSERT = 8'b0001_0000,
    S_FREAD  = 8'b0010_0000,
    S_FEMIT  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  function automatic logic [SW-1:0] wrap_slot(input logic [SW:0] s);
    logic [SW:0] r;
    r = (s >= WIN_WRAP) ? (s - WIN_WRAP) : s;
    return r[SW-1:0];
  endfunction

  state_t state, state_next;

  logic [POS_W-1:0] radius;
  logic [SW-1:0]    oldest;
  logic [CW-1:0]    open_cnt;
  logic [CW-1:0]    scan_k;
  logic             pipe_v;
  logic [SW-1:0]    pipe_slot;

  logic [CHROM_W-1:0] it_c1, it_c2;
  logic [POS_W-1:0]   it_p1, it_p2;
  logic [IDX_W-1:0]   it_idx;
  logic               it_last;
  logic [POS_W-1:0]   new_lo;
  logic [POS_W:0]     new_hi;
  logic [CNT_W-1:0]   tally_new;

  entry_t           ent_wdata, ent_rdata;
  logic             ent_we;
  logic [SW-1:0]    rd_addr, ins_slot, scan_slot, oldest_next;
  logic             tal_we;
  logic [SW-1:0]    tal_waddr;
  logic [CNT_W-1:0] tal_wdata, tal_rdata;

  rq_ctl_t ctl;
  logic    rq_rdy;
  logic    pop;
  logic    scan_issue;
  logic    accept;

  logic [POS_W:0] first_diff;
  logic           first_near;
  logic           same2;
  logic [POS_W:0] y_hi;
  logic           y_in_new, new_in_y;

  assign pairs.ready = (state == S_IDLE);
  assign accept      = pairs.valid && pairs.ready;

  assign scan_slot   = wrap_slot({1'b0, oldest} + (SW + 1)'(scan_k));
  assign ins_slot    = wrap_slot({1'b0, oldest} + (SW + 1)'(open_cnt));
  assign oldest_next = (oldest == LAST_SLOT) ? '0 : oldest + 1'b1;
  assign rd_addr     = scan_issue ? scan_slot : oldest;

  // age test of the oldest entry against the new first end
  assign first_diff = {1'b0, it_p1} - {1'b0, ent_rdata.first_pos};
  assign first_near = (ent_rdata.first_chrom == it_c1) && (first_diff < {1'b0, radius});

  // second-end tests in both directions
  assign same2    = (ent_rdata.second_chrom == it_c2);
  assign y_hi     = {1'b0, ent_rdata.second_pos} + {1'b0, radius};
  assign y_in_new = same2 && (ent_rdata.second_pos > new_lo)
                    && ({1'b0, ent_rdata.second_pos} < new_hi);
  assign new_in_y = same2 && ({1'b0, it_p2} < y_hi)
                    && ((ent_rdata.second_pos > radius) ? (new_hi > {1'b0, ent_rdata.second_pos})
                                                        : (it_p2 != '0));

  assign ent_we    = (state == S_INSERT);
  assign ent_wdata = '{first_chrom: it_c1, first_pos: it_p1, second_chrom: it_c2,
                       second_pos: it_p2, index: it_idx};

  always_comb begin
    tal_we    = pipe_v || (state == S_INSERT);
    tal_waddr = pipe_v ? pipe_slot : ins_slot;
    if (!pipe_v) begin
      tal_wdata = tally_new;
    end else if (new_in_y && (tal_rdata != TALLY_MAX)) begin
      tal_wdata = tal_rdata + 1'b1;
    end else begin
      tal_wdata = tal_rdata;
    end
  end

  wnpc_ram #(.WIDTH($bits(entry_t)), .DEPTH(WINDOW)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ins_slot),
    .wdata (ent_wdata),
    .raddr (rd_addr),
    .rdata (ent_rdata)
  );

  wnpc_ram #(.WIDTH(CNT_W), .DEPTH(WINDOW)) u_tally_ram (
    .clk   (clk),
    .we    (tal_we),
    .waddr (tal_waddr),
    .wdata (tal_wdata),
    .raddr (rd_addr),
    .rdata (tal_rdata)
  );

  wnpc_result_q u_result_q (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rdy    (rq_rdy),
    .counts (counts)
  );

  always_comb begin
    state_next    = state;
    ctl           = '0;
    ctl.res.idx   = ent_rdata.index;
    ctl.res.count = tal_rdata;
    pop           = 1'b0;
    scan_issue    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (pairs.valid) begin
          state_next = (open_cnt != '0) ? S_CHECK : S_INSERT;
        end
      end
      S_CHECK: begin
        if (!first_near) begin
          ctl.push = 1'b1;
          if (rq_rdy) begin
            pop        = 1'b1;
            state_next = (open_cnt > CW'(1)) ? S_READ : S_INSERT;
          end
        end else if (open_cnt == WIN_CNT) begin
          ctl.push    = 1'b1;
          ctl.res.ovf = 1'b1;
          if (rq_rdy) begin
            pop        = 1'b1;
            state_next = S_SCAN;
          end
        end else begin
          state_next = S_SCAN;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_SCAN: begin
        if (scan_k == open_cnt) begin
          state_next = S_INSERT;
        end else begin
          scan_issue = 1'b1;
        end
      end
      S_INSERT: begin
        state_next = it_last ? S_FREAD : S_DONE;
      end
      S_FREAD: begin
        state_next = S_FEMIT;
      end
      S_FEMIT: begin
        ctl.push = 1'b1;
        if (rq_rdy) begin
          pop        = 1'b1;
          state_next = (open_cnt > CW'(1)) ? S_FREAD : S_DONE;
        end
      end
      S_DONE: begin
        ctl.finish = 1'b1;
        if (rq_rdy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      radius   <= RADIUS_RESET;
      oldest   <= '0;
      open_cnt <= '0;
      scan_k   <= '0;
      pipe_v   <= 1'b0;
    end else begin
      state  <= state_next;
      pipe_v <= scan_issue;
      if (cfg_we) begin
        radius <= cfg_data;
      end
      if (scan_issue) begin
        scan_k <= scan_k + 1'b1;
      end else if (state != S_SCAN) begin
        scan_k <= '0;
      end
      if (pop) begin
        oldest   <= oldest_next;
        open_cnt <= open_cnt - 1'b1;
      end else if (state == S_INSERT) begin
        open_cnt <= open_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_slot <= scan_slot;
    if (accept) begin
      it_c1     <= pairs.first_chrom;
      it_p1     <= pairs.first_pos;
      it_c2     <= pairs.second_chrom;
      it_p2     <= pairs.second_pos;
      it_idx    <= pairs.item_index;
      it_last   <= pairs.last_item;
      new_lo    <= (pairs.second_pos > radius) ? (pairs.second_pos - radius) : '0;
      new_hi    <= {1'b0, pairs.second_pos} + {1'b0, radius};
      tally_new <= '0;
    end else if (pipe_v && y_in_new && (tally_new != TALLY_MAX)) begin
      tally_new <= tally_new + 1'b1;
    end
  end

  `WNPC_ASSERT_NOW(a_scan_no_overlap, pipe_v && scan_issue, pipe_slot != scan_slot, "slot reuse")
  `WNPC_ASSERT_NOW(a_insert_not_full, state == S_INSERT, open_cnt < WIN_CNT, "full on insert")
  `WNPC_ASSERT_NEXT(a_insert_grows, state == S_INSERT, open_cnt == $past(open_cnt) + 1'b1, "no growth")
  `WNPC_ASSERT_NOW(a_flush_empties, (state == S_DONE) && it_last, open_cnt == '0, "flush incomplete")

endmodule
